### design/assert_macros.svh
// Assertion macros for the RTL of the replacer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Types and codes shared by the hot/cold clock replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

    // Command kinds
    localparam logic [1:0] KIND_VICTIM = 2'd0;
    localparam logic [1:0] KIND_PIN    = 2'd1;
    localparam logic [1:0] KIND_UNPIN  = 2'd2;

    // Threshold after reset
    localparam logic [7:0] HOT_SKIP_RESET = 8'd5;

    // One command transfer
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] frame;
        logic       hot;
    } t_cmd;

    // One result transfer
    typedef struct packed {
        logic       found;
        logic [5:0] victim_frame;
        logic [6:0] evictable_count;
    } t_result;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP1,
        ST_SWEEP2
    } t_state;

    // Per-cycle sweep decisions
    typedef struct packed {
        logic evict;
        logic clr_ref;
        logic cnt_hot;
        logic last;
    } t_sweep_ctl;

endpackage

`default_nettype wire

### design/hot_cold_clock_replacer.sv
// ----------------------------------------------------------------------------
// hot_cold_clock_replacer
// Clock page replacer with hot/cold frames and a skip threshold for hot ones.
//
// Channel   Direction  Signals                       Transfer
// command   in         start, busy, i_cmd            start high, busy low
// result    out        o_done, o_result              o_done high, one cycle
// config    in         i_cfg_we, i_cfg_wdata         i_cfg_we high
//
// Pin, unpin, an unknown kind and a victim request with no evictable frame:
// busy stays low, the result strobes the cycle after the command transfer.
// A victim request visits one frame per cycle at the hand, in a first sweep
// and, if that finds no victim, a second sweep; busy stays high until a
// victim is evicted or the second sweep ends.
// Reset is synchronous and restores all frame bits, the hand and the count.
// The receiver takes every result; nothing stalls the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hot_cold_clock_replacer #(
    parameter int FRAMES = 64
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  hcc_pkg::t_cmd   i_cmd,
    output logic            o_done,
    output hcc_pkg::t_result o_result,
    input  wire             i_cfg_we,
    input  wire [7:0]       i_cfg_wdata
);

    localparam int FW   = $clog2(FRAMES);
    localparam int CNTW = $clog2(FRAMES + 1);
    localparam int CW   = (CNTW > 6) ? CNTW : 6;

    // State
    hcc_pkg::t_state     r_state, n_state;
    logic [FRAMES-1:0]   r_evict;
    logic [FRAMES-1:0]   r_ref;
    logic [FRAMES-1:0]   r_hot;
    logic [FW-1:0]       r_hand;
    logic [FW-1:0]       r_step;
    logic [CNTW-1:0]     r_total;
    logic [7:0]          r_thr;
    logic [7:0]          r_passed;
    logic                r_done;
    logic                r_found;
    logic [5:0]          r_victim;

    hcc_pkg::t_sweep_ctl ctl;
    logic                cur_ev;
    logic                cur_ref;
    logic                cur_hot;
    logic [8:0]          pass_inc;
    logic                hot_hit;
    logic [FW-1:0]       hand_next;
    logic [CW-1:0]       cmd_frame_x;
    logic [FW-1:0]       cmd_idx;
    logic                in_range;
    logic                accept;

    // Decode the frame at the hand
    assign cur_ev    = r_evict[r_hand];
    assign cur_ref   = r_ref[r_hand];
    assign cur_hot   = r_hot[r_hand];
    assign pass_inc  = {1'b0, r_passed} + 9'd1;
    assign hot_hit   = pass_inc >= {1'b0, r_thr};
    assign hand_next = (r_hand == FW'(FRAMES - 1)) ? '0 : r_hand + 1'b1;

    // Decode the command frame
    assign cmd_frame_x = CW'(i_cmd.frame);
    assign cmd_idx     = cmd_frame_x[FW-1:0];
    assign in_range    = cmd_frame_x < CW'(FRAMES);
    assign accept      = start && !busy;

    // Sequencer outputs and sweep decisions
    always_comb begin
        busy        = (r_state != hcc_pkg::ST_IDLE);
        ctl         = '0;
        ctl.last    = (r_step == FW'(FRAMES - 1));
        unique case (r_state)
            hcc_pkg::ST_SWEEP1: begin
                ctl.evict   = cur_ev && !cur_ref && (!cur_hot || hot_hit);
                ctl.cnt_hot = cur_ev && !cur_ref && cur_hot;
                ctl.clr_ref = cur_ev && !ctl.evict;
            end
            hcc_pkg::ST_SWEEP2: begin
                ctl.evict   = cur_ev && !cur_ref;
                ctl.clr_ref = !ctl.evict;
            end
            default: begin
                ctl.evict   = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcc_pkg::ST_IDLE: begin
                if (accept && (i_cmd.kind == hcc_pkg::KIND_VICTIM) && (r_total != '0)) begin
                    n_state = hcc_pkg::ST_SWEEP1;
                end
            end
            hcc_pkg::ST_SWEEP1: begin
                if (ctl.evict) begin
                    n_state = hcc_pkg::ST_IDLE;
                end else if (ctl.last) begin
                    n_state = hcc_pkg::ST_SWEEP2;
                end
            end
            hcc_pkg::ST_SWEEP2: begin
                if (ctl.evict || ctl.last) begin
                    n_state = hcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hcc_pkg::ST_IDLE;
            end
        endcase
    end

    // Frame bits, hand, count and sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hcc_pkg::ST_IDLE;
            r_evict  <= '0;
            r_ref    <= '0;
            r_hot    <= '1;
            r_hand   <= '0;
            r_step   <= '0;
            r_total  <= '0;
            r_thr    <= hcc_pkg::HOT_SKIP_RESET;
            r_passed <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_state == hcc_pkg::ST_IDLE) begin
                if (accept) begin
                    case (i_cmd.kind)
                        hcc_pkg::KIND_VICTIM: begin
                            r_step   <= '0;
                            r_passed <= '0;
                            if (r_total == '0) begin
                                r_done <= 1'b1;
                            end
                        end
                        hcc_pkg::KIND_PIN: begin
                            r_done <= 1'b1;
                            if (in_range && r_evict[cmd_idx]) begin
                                r_evict[cmd_idx] <= 1'b0;
                                r_total          <= r_total - 1'b1;
                            end
                        end
                        hcc_pkg::KIND_UNPIN: begin
                            r_done <= 1'b1;
                            if (in_range && !r_evict[cmd_idx]) begin
                                r_evict[cmd_idx] <= 1'b1;
                                r_ref[cmd_idx]   <= 1'b1;
                                r_hot[cmd_idx]   <= i_cmd.hot;
                                r_total          <= r_total + 1'b1;
                            end
                        end
                        default: begin
                            r_done <= 1'b1;
                        end
                    endcase
                end
            end else begin
                // One frame per cycle at the hand
                r_hand <= hand_next;
                if (ctl.evict) begin
                    r_evict[r_hand] <= 1'b0;
                    r_total         <= r_total - 1'b1;
                    r_done          <= 1'b1;
                end else begin
                    if (ctl.clr_ref) begin
                        r_ref[r_hand] <= 1'b0;
                    end
                    if (ctl.cnt_hot) begin
                        r_passed <= pass_inc[7:0];
                    end
                    r_step <= ctl.last ? '0 : r_step + 1'b1;
                    if (ctl.last && (r_state == hcc_pkg::ST_SWEEP2)) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if ((r_state != hcc_pkg::ST_IDLE) && ctl.evict) begin
            r_found  <= 1'b1;
            r_victim <= 6'(r_hand);
        end else begin
            r_found  <= 1'b0;
            r_victim <= '0;
        end
    end

    // Drive result transfer
    assign o_done                   = r_done;
    assign o_result.found           = r_found;
    assign o_result.victim_frame    = r_victim;
    assign o_result.evictable_count = 7'(r_total);

    // Checks
    `ASSERT_CLK(a_done_not_busy, i_clk, i_rst_n, o_done |-> !busy, "result while busy")
    `ASSERT_CLK(a_count_matches, i_clk, i_rst_n, ($countones(r_evict) == int'(r_total)), "evictable count mismatch")
    `ASSERT_CLK(a_pin_one_cycle, i_clk, i_rst_n, (accept && (i_cmd.kind != hcc_pkg::KIND_VICTIM)) |=> o_done, "pin or unpin result missing")
    `ASSERT_CLK(a_found_drops_count, i_clk, i_rst_n, (o_done && o_result.found) |-> (CNTW'(r_total + 1'b1) == $past(r_total)), "eviction did not lower count")
    `ASSERT_CLK_ALWAYS(a_reset_idle, i_clk, (!i_rst_n) |=> (!o_done && !busy), "not idle after reset")

endmodule

`default_nettype wire

### test/hot_cold_clock_replacer_checker.sv
// ----------------------------------------------------------------------------
// hot_cold_clock_replacer_checker
// Watches the command, result and threshold channels of the replacer, keeps a
// shadow copy of the frame bits, hand and count, predicts each result and
// compares it field by field with the result strobed by the block.
// ----------------------------------------------------------------------------

module hot_cold_clock_replacer_checker (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire              i_busy,
    input  hcc_pkg::t_cmd    i_cmd,
    input  wire              i_done,
    input  hcc_pkg::t_result i_result,
    input  wire              i_cfg_we,
    input  wire [7:0]        i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_cmd_count,
    output int               o_result_count,
    output int               o_evict_count
);

    localparam int NFRAMES    = 64;
    localparam int REPORT_MAX = 10;

    // Shadow replacer state
    logic [NFRAMES-1:0] evictable_q;
    logic [NFRAMES-1:0] referenced_q;
    logic [NFRAMES-1:0] hot_q;
    logic [5:0]         hand_q;
    logic [6:0]         total_q;
    logic [7:0]         threshold_q;

    // Results still owed by the block, oldest first
    hcc_pkg::t_result owed_results[$];

    int fail_n   = 0;
    int cmd_n    = 0;
    int result_n = 0;
    int evict_n  = 0;

    // Remove a frame, move the hand past it and build the victim result
    function automatic hcc_pkg::t_result evict_frame(logic [5:0] p);
        hcc_pkg::t_result r;
        evictable_q[p] = 1'b0;
        total_q        = total_q - 7'd1;
        hand_q         = p + 6'd1;
        r.found           = 1'b1;
        r.victim_frame    = p;
        r.evictable_count = total_q;
        return r;
    endfunction

    // Two sweeps from the hand: cold or Nth hot unreferenced first, then any
    function automatic hcc_pkg::t_result choose_victim();
        hcc_pkg::t_result r;
        int               passed;
        int               i;
        logic [5:0]       p;
        r = '0;
        r.evictable_count = total_q;
        passed = 0;
        if (total_q == 7'd0) return r;
        for (i = 0; i < NFRAMES; i++) begin
            p = hand_q;
            if (evictable_q[p]) begin
                if (!referenced_q[p]) begin
                    if (!hot_q[p]) return evict_frame(p);
                    passed++;
                    // a threshold of zero acts as one here
                    if (passed >= int'(threshold_q)) return evict_frame(p);
                end
                referenced_q[p] = 1'b0;
            end
            hand_q = p + 6'd1;
        end
        for (i = 0; i < NFRAMES; i++) begin
            p = hand_q;
            if (evictable_q[p] && !referenced_q[p]) return evict_frame(p);
            referenced_q[p] = 1'b0;
            hand_q = p + 6'd1;
        end
        return r;
    endfunction

    // Apply one command to the shadow state and return its result
    function automatic hcc_pkg::t_result predict_result(hcc_pkg::t_cmd c);
        hcc_pkg::t_result r;
        r = '0;
        case (c.kind)
            hcc_pkg::KIND_VICTIM: begin
                r = choose_victim();
            end
            hcc_pkg::KIND_PIN: begin
                if (evictable_q[c.frame]) begin
                    evictable_q[c.frame] = 1'b0;
                    total_q = total_q - 7'd1;
                end
                r.evictable_count = total_q;
            end
            hcc_pkg::KIND_UNPIN: begin
                // unpin of an evictable frame leaves every bit alone
                if (!evictable_q[c.frame]) begin
                    evictable_q[c.frame]  = 1'b1;
                    referenced_q[c.frame] = 1'b1;
                    hot_q[c.frame]        = c.hot;
                    total_q = total_q + 7'd1;
                end
                r.evictable_count = total_q;
            end
            default: begin
                r.evictable_count = total_q;
            end
        endcase
        return r;
    endfunction

    // Track transfers on every channel
    always @(posedge i_clk) begin : monitor
        hcc_pkg::t_result want;
        if (!i_rst_n) begin
            evictable_q  = '0;
            referenced_q = '0;
            hot_q        = '1;
            hand_q       = '0;
            total_q      = '0;
            threshold_q  = hcc_pkg::HOT_SKIP_RESET;
            owed_results.delete();
        end else begin
            if (i_cfg_we) threshold_q = i_cfg_wdata;
            // queue the prediction before matching, in case both land together
            if (i_start && !i_busy) begin
                owed_results.push_back(predict_result(i_cmd));
                cmd_n++;
            end
            if (i_done) begin
                result_n++;
                if (owed_results.size() == 0) begin
                    fail_n++;
                    if (fail_n <= REPORT_MAX)
                        $display("[%0t] ERROR: result with no command owed: %s%0d %s%0d %s%0d",
                                 $time, "found=", i_result.found,
                                 "victim=", i_result.victim_frame,
                                 "count=", i_result.evictable_count);
                end else begin
                    want = owed_results.pop_front();
                    if (want.found) evict_n++;
                    if (i_result.found !== want.found ||
                        i_result.victim_frame !== want.victim_frame ||
                        i_result.evictable_count !== want.evictable_count) begin
                        fail_n++;
                        if (fail_n <= REPORT_MAX)
                            $display("[%0t] ERROR: result %0d expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $time, result_n, want.found, want.victim_frame,
                                     want.evictable_count, i_result.found,
                                     i_result.victim_frame, i_result.evictable_count);
                    end
                end
            end
        end
        o_pending      <= owed_results.size();
        o_fail_count   <= fail_n;
        o_cmd_count    <= cmd_n;
        o_result_count <= result_n;
        o_evict_count  <= evict_n;
    end

endmodule

### test/tb_hot_cold_clock_replacer.sv
// ----------------------------------------------------------------------------
// tb_hot_cold_clock_replacer
// Drives the replacer with a directed set of pin, unpin, victim and unknown
// commands, then random phases under several skip thresholds, with bursty
// command timing. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_hot_cold_clock_replacer;

    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         RANDOM_PHASES = 5;
    localparam int         PHASE_ITEMS   = 80;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    hcc_pkg::t_cmd    i_cmd       = '0;
    logic             o_done;
    hcc_pkg::t_result o_result;
    logic             i_cfg_we    = 1'b0;
    logic [7:0]       i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int cmd_count;
    int result_count;
    int evict_count;

    int burst_left    = 0;
    bit no_gaps       = 1'b0;
    int cycles        = 0;
    int setting_count = 0;

    hot_cold_clock_replacer #(
        .FRAMES (64)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    hot_cold_clock_replacer_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_done         (o_done),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_cmd_count    (cmd_count),
        .o_result_count (result_count),
        .o_evict_count  (evict_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // End the run if the block stops answering
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still owed", cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic hcc_pkg::t_cmd mk_cmd(logic [1:0] k, logic [5:0] f, logic h);
        hcc_pkg::t_cmd c;
        c.kind  = k;
        c.frame = f;
        c.hot   = h;
        return c;
    endfunction

    // Present one command and hold it until the transfer; idle for a random gap between some bursts
    task automatic send_cmd(hcc_pkg::t_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    // Drop start and wait until every owed result has come back
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        setting_count++;
    endtask

    initial begin : stimulus
        int            ph;
        int            n;
        int            roll;
        int            span;
        int            unpin_pct;
        logic [5:0]    base;
        logic [7:0]    thr;
        hcc_pkg::t_cmd c;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty victim, unknown kind, redundant pin and unpin,
        // cold eviction in the first sweep, fallback to the second sweep
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));
        send_cmd(mk_cmd(KIND_UNKNOWN,         6'd63, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_PIN,    6'd0,  1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd0,  1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd63, 1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd63, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd1,  1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd2,  1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd63, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_PIN,    6'd2,  1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_PIN,    6'd2,  1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));

        // Directed: a threshold of one evicts the first unreferenced hot frame
        settle();
        set_threshold(8'd1);
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd10, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd20, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));

        // Directed: zero threshold acts as one
        settle();
        set_threshold(8'd0);
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd30, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd31, 1'b1));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));

        // Directed: highest threshold, a cold frame evicted, then an unknown kind
        settle();
        set_threshold(8'd255);
        send_cmd(mk_cmd(hcc_pkg::KIND_UNPIN,  6'd40, 1'b0));
        send_cmd(mk_cmd(hcc_pkg::KIND_VICTIM, 6'd0,  1'b0));
        send_cmd(mk_cmd(KIND_UNKNOWN,         6'd0,  1'b0));

        // Random phases, each under its own threshold and working set
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0:       thr = 8'd1;
                1:       thr = 8'd255;
                2:       thr = 8'($urandom_range(2, 12));
                3:       thr = 8'd0;
                default: thr = hcc_pkg::HOT_SKIP_RESET;
            endcase
            set_threshold(thr);
            no_gaps   = (ph == 2);
            unpin_pct = $urandom_range(40, 60);
            base      = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 2))
                0:       span = 8;
                1:       span = 16;
                default: span = 64;
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    c.kind = KIND_UNKNOWN;
                else if (roll < 20)
                    c.kind = hcc_pkg::KIND_PIN;
                else if (roll < 20 + unpin_pct)
                    c.kind = hcc_pkg::KIND_UNPIN;
                else
                    c.kind = hcc_pkg::KIND_VICTIM;
                c.frame = 6'(base + $urandom_range(0, span - 1));
                c.hot   = ($urandom_range(0, 99) < 70);
                send_cmd(c);
            end
        end

        // Drain and report
        settle();
        repeat (16) @(posedge i_clk);
        $display("Run summary: %0d commands, %0d results, %0d evictions",
                 cmd_count, result_count, evict_count);
        $display("Skip threshold written %0d times, including 0, 1, 255 and the reset value",
                 setting_count);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### hot_cold_clock_replacer.f
+incdir+design
design/hcc_pkg.sv
design/hot_cold_clock_replacer.sv
test/hot_cold_clock_replacer_checker.sv
test/tb_hot_cold_clock_replacer.sv
